// ===== src/serial_command_packet_framer_unit_assert.svh =====
// Assertion macros for the serial command packet framer.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef SERIAL_COMMAND_PACKET_FRAMER_UNIT_ASSERT_SVH
`define SERIAL_COMMAND_PACKET_FRAMER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SCPF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SCPF_ASSERT_NEVER(lbl, cond, msg) \
	`SCPF_ASSERT(lbl, !(cond), msg)
`else
`define SCPF_ASSERT(lbl, prop, msg)
`define SCPF_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/scpf_pkg.sv =====
// Shared constants and the frame record type of the command packet framer.
// No dependencies.
package scpf_pkg;
	localparam int MAX_PARAMS   = 8;
	localparam int PARAM_FIELDS = 8;
	localparam int CAP_COUNT    = (MAX_PARAMS < PARAM_FIELDS) ? MAX_PARAMS : PARAM_FIELDS;
	localparam int HEADER_BYTES = 3;
	localparam int FRAME_BYTES  = CAP_COUNT + HEADER_BYTES + 1;
	localparam int IDX_W        = $clog2(FRAME_BYTES);
	localparam int PIDX_W       = $clog2(PARAM_FIELDS);
	localparam int CNT_W        = 4;
	localparam int SEQ_SHIFT    = 4;
	localparam int IFACE_SHIFT  = 6;
	localparam logic [7:0] START_BYTE = 8'h02;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [CNT_W-1:0]              cnt;
		byte_t                         seq_byte;
		byte_t                         ctrl_byte;
		byte_t [PARAM_FIELDS-1:0]      params;
		byte_t                         sum;
	} frame_t;
endpackage

// ===== src/scpf_frame_builder.sv =====
// Builds the frame record of one request: capped count, header bytes, checksum.
// Depends on scpf_pkg.
module scpf_frame_builder (
	input  logic [3:0]                     seq_number,
	input  logic [3:0]                     param_count,
	input  logic [1:0]                     target_iface,
	input  logic [5:0]                     command_code,
	input  scpf_pkg::byte_t [scpf_pkg::PARAM_FIELDS-1:0] params,
	output scpf_pkg::frame_t               frame
);
	logic [scpf_pkg::CNT_W-1:0] cnt;
	scpf_pkg::byte_t            seq_byte;
	scpf_pkg::byte_t            ctrl_byte;
	scpf_pkg::byte_t            sum;

	always_comb begin
		if (param_count > scpf_pkg::CNT_W'(scpf_pkg::CAP_COUNT)) begin
			cnt = scpf_pkg::CNT_W'(scpf_pkg::CAP_COUNT);
		end else begin
			cnt = param_count;
		end
		seq_byte  = (8'(seq_number) << scpf_pkg::SEQ_SHIFT) | 8'(cnt);
		ctrl_byte = (8'(target_iface) << scpf_pkg::IFACE_SHIFT) | 8'(command_code);
		sum = seq_byte ^ ctrl_byte;
		for (int i = 0; i < scpf_pkg::PARAM_FIELDS; i++) begin
			if (scpf_pkg::CNT_W'(i) < cnt) begin
				sum = sum ^ params[i];
			end
		end
		frame.cnt       = cnt;
		frame.seq_byte  = seq_byte;
		frame.ctrl_byte = ctrl_byte;
		frame.params    = params;
		frame.sum       = sum;
	end
endmodule

// ===== src/serial_command_packet_framer_unit.sv =====
// Command packet framer: one request in, a framed byte stream out.
// The request is registered in the frame stage, then each byte in the output register.
// Throughput: one byte per cycle, set by the single output byte port, while out_stall is low;
// a packet of count c has c + 4 bytes (4..12); the next request enters as the last byte leaves.
// Reset: arst_n clears the frame and output valid flags asynchronously.
// Depends on scpf_pkg, scpf_frame_builder and serial_command_packet_framer_unit_assert.svh.
`include "serial_command_packet_framer_unit_assert.svh"
module serial_command_packet_framer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] seq_number,
	input  logic [3:0] param_count,
	input  logic [1:0] target_iface,
	input  logic [5:0] command_code,
	input  logic [7:0] param_0,
	input  logic [7:0] param_1,
	input  logic [7:0] param_2,
	input  logic [7:0] param_3,
	input  logic [7:0] param_4,
	input  logic [7:0] param_5,
	input  logic [7:0] param_6,
	input  logic [7:0] param_7,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] byte_out,
	output logic       last_byte
);
	scpf_pkg::byte_t [scpf_pkg::PARAM_FIELDS-1:0] params;
	scpf_pkg::frame_t           built;
	scpf_pkg::frame_t           frame_s1;
	logic                       valid_s1;
	logic [scpf_pkg::IDX_W-1:0] idx_q;
	logic [scpf_pkg::IDX_W-1:0] last_idx;
	logic [scpf_pkg::IDX_W-1:0] idx_m3;
	logic                       sel_last;
	scpf_pkg::byte_t            sel_byte;
	logic                       load;
	logic                       out_valid_q;
	scpf_pkg::byte_t            byte_q;
	logic                       last_q;
	logic                       in_take;

	assign params = {param_7, param_6, param_5, param_4, param_3, param_2, param_1, param_0};

	scpf_frame_builder u_builder (
		.seq_number   (seq_number),
		.param_count  (param_count),
		.target_iface (target_iface),
		.command_code (command_code),
		.params       (params),
		.frame        (built)
	);

	always_comb begin
		last_idx = scpf_pkg::IDX_W'(frame_s1.cnt) + scpf_pkg::IDX_W'(scpf_pkg::HEADER_BYTES);
		idx_m3   = idx_q - scpf_pkg::IDX_W'(scpf_pkg::HEADER_BYTES);
		sel_last = (idx_q == last_idx);
		priority if (idx_q == scpf_pkg::IDX_W'(0)) begin
			sel_byte = scpf_pkg::START_BYTE;
		end else if (idx_q == scpf_pkg::IDX_W'(1)) begin
			sel_byte = frame_s1.seq_byte;
		end else if (idx_q == scpf_pkg::IDX_W'(2)) begin
			sel_byte = frame_s1.ctrl_byte;
		end else if (sel_last) begin
			sel_byte = frame_s1.sum;
		end else begin
			sel_byte = frame_s1.params[idx_m3[scpf_pkg::PIDX_W-1:0]];
		end
	end

	assign load     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !(load && sel_last);
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
			idx_q    <= '0;
		end else if (load) begin
			if (sel_last) begin
				valid_s1 <= 1'b0;
			end else begin
				idx_q <= idx_q + scpf_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			frame_s1 <= built;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel_byte;
			last_q <= sel_last;
		end
	end

	assign out_valid = out_valid_q;
	assign byte_out  = byte_q;
	assign last_byte = last_q;

	`SCPF_ASSERT(a_idx_in_frame, valid_s1 |-> (idx_q <= last_idx), "frame index past checksum")
	`SCPF_ASSERT(a_take_restarts, in_take |=> (valid_s1 && idx_q == '0), "request not started")
	`SCPF_ASSERT_NEVER(a_orphan_byte, out_valid_q && !last_q && !valid_s1, "frame dropped early")
endmodule

// ===== test/tb_top.sv =====
// Testbench for serial_command_packet_framer_unit: drives command requests and
// checks every framed byte and its last flag against a scoreboard prediction.
// Depends on scpf_pkg and the framer RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0]                                   seq;
		logic [3:0]                                   cnt;
		logic [1:0]                                   iface;
		logic [5:0]                                   cmd;
		scpf_pkg::byte_t [scpf_pkg::PARAM_FIELDS-1:0] params;
	} cmd_req_t;

	typedef struct packed {
		scpf_pkg::byte_t data;
		logic            last;
	} line_byte_t;

	class frame_scoreboard;
		line_byte_t pending_bytes[$];
		int unsigned errors;

		function new();
			errors = 0;
		endfunction

		function void note_request(cmd_req_t r);
			logic [3:0]      n;
			scpf_pkg::byte_t seq_b;
			scpf_pkg::byte_t ctrl_b;
			scpf_pkg::byte_t sum;
			line_byte_t      b;
			n = (r.cnt > scpf_pkg::CAP_COUNT) ? 4'(scpf_pkg::CAP_COUNT) : r.cnt;
			seq_b = (scpf_pkg::byte_t'(r.seq) << scpf_pkg::SEQ_SHIFT) | scpf_pkg::byte_t'(n);
			ctrl_b = (scpf_pkg::byte_t'(r.iface) << scpf_pkg::IFACE_SHIFT)
			         | scpf_pkg::byte_t'(r.cmd);
			sum = seq_b ^ ctrl_b;
			b.last = 1'b0;
			b.data = scpf_pkg::START_BYTE;
			pending_bytes.push_back(b);
			b.data = seq_b;
			pending_bytes.push_back(b);
			b.data = ctrl_b;
			pending_bytes.push_back(b);
			for (int i = 0; i < n; i++) begin
				b.data = r.params[i];
				sum ^= r.params[i];
				pending_bytes.push_back(b);
			end
			b.data = sum;
			b.last = 1'b1;
			pending_bytes.push_back(b);
		endfunction

		function void check_byte(scpf_pkg::byte_t data, logic last);
			line_byte_t want;
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected byte: expected none, actual %h last %b",
					$time, data, last);
				errors++;
				return;
			end
			want = pending_bytes.pop_front();
			if (data !== want.data) begin
				$display("%0t: byte_out mismatch: expected %h, actual %h",
					$time, want.data, data);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: last_byte mismatch: expected %b, actual %b",
					$time, want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [3:0] seq_number;
	logic [3:0] param_count;
	logic [1:0] target_iface;
	logic [5:0] command_code;
	logic [7:0] param_0;
	logic [7:0] param_1;
	logic [7:0] param_2;
	logic [7:0] param_3;
	logic [7:0] param_4;
	logic [7:0] param_5;
	logic [7:0] param_6;
	logic [7:0] param_7;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] byte_out;
	logic       last_byte;

	frame_scoreboard sb;
	bit              idle_en;
	int unsigned     cycle_cnt;

	serial_command_packet_framer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.seq_number   (seq_number),
		.param_count  (param_count),
		.target_iface (target_iface),
		.command_code (command_code),
		.param_0      (param_0),
		.param_1      (param_1),
		.param_2      (param_2),
		.param_3      (param_3),
		.param_4      (param_4),
		.param_5      (param_5),
		.param_6      (param_6),
		.param_7      (param_7),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_out     (byte_out),
		.last_byte    (last_byte)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (arst_n && out_valid && !out_stall)
			sb.check_byte(byte_out, last_byte);
	end

	// hold stall in bursts, with calm stretches in between
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_en && ((cycle_cnt / 64) % 3 != 0) && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_request(cmd_req_t r, bit allow_gap);
		if (allow_gap && idle_en && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		seq_number   <= r.seq;
		param_count  <= r.cnt;
		target_iface <= r.iface;
		command_code <= r.cmd;
		param_0      <= r.params[0];
		param_1      <= r.params[1];
		param_2      <= r.params[2];
		param_3      <= r.params[3];
		param_4      <= r.params[4];
		param_5      <= r.params[5];
		param_6      <= r.params[6];
		param_7      <= r.params[7];
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		sb.note_request(r);
	endtask

	function automatic cmd_req_t random_request();
		cmd_req_t r;
		r.seq   = 4'($urandom);
		r.cnt   = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
		                                       : 4'($urandom_range(9, 15));
		r.iface = 2'($urandom);
		r.cmd   = 6'($urandom);
		for (int k = 0; k < scpf_pkg::PARAM_FIELDS; k++)
			r.params[k] = 8'($urandom);
		return r;
	endfunction

	initial begin
		cmd_req_t r;
		sb = new();
		idle_en = 1'b1;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		seq_number   <= '0;
		param_count  <= '0;
		target_iface <= '0;
		command_code <= '0;
		param_0      <= '0;
		param_1      <= '0;
		param_2      <= '0;
		param_3      <= '0;
		param_4      <= '0;
		param_5      <= '0;
		param_6      <= '0;
		param_7      <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sweep every count, including those above the cap
		for (int c = 0; c < 16; c++) begin
			r.seq   = 4'(c);
			r.cnt   = 4'(c);
			r.iface = 2'(c);
			r.cmd   = c[0] ? 6'h3F : 6'h00;
			for (int k = 0; k < scpf_pkg::PARAM_FIELDS; k++)
				r.params[k] = c[0] ? 8'hFF : 8'(c * 17 + k);
			send_request(r, 1'b1);
		end
		r.seq = 4'hF;
		r.cnt = 4'd8;
		r.iface = 2'd3;
		r.cmd = 6'h3F;
		r.params = '1;
		send_request(r, 1'b1);
		r = '0;
		r.cnt = 4'd8;
		send_request(r, 1'b1);

		for (int i = 0; i < 150; i++) begin
			if (i >= 125)
				idle_en = 1'b0;
			r = random_request();
			send_request(r, (i / 20) % 3 != 2);
		end
		in_valid <= 1'b0;

		while (sb.pending_bytes.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
